@@ rtl/core/mdir_pkg.sv @@
// ----------------------------------------------------------------------------
// mdir_pkg
// Shared constants and types of the two-sensor motion direction detector.
// ----------------------------------------------------------------------------
package mdir_pkg;

	localparam int HISTORY_DEPTH = 8;
	localparam int SAMPLE_BITS   = 12;
	localparam int THRESH_BITS   = 12;
	localparam int CMP_BITS      = (SAMPLE_BITS > THRESH_BITS) ? SAMPLE_BITS : THRESH_BITS;
	localparam int CNT_BITS      = $clog2(HISTORY_DEPTH);
	localparam int DIR_BITS      = 2;

	localparam logic [THRESH_BITS-1:0] THRESH_RESET = THRESH_BITS'(2);

	localparam logic [DIR_BITS-1:0] DIR_NONE  = 2'd0;
	localparam logic [DIR_BITS-1:0] DIR_RIGHT = 2'd1;
	localparam logic [DIR_BITS-1:0] DIR_LEFT  = 2'd2;

	typedef logic [SAMPLE_BITS-1:0] sample_t;

	typedef enum logic [1:0] {
		TREND_NEUTRAL,
		TREND_UP,
		TREND_DOWN
	} trend_t;

	// Pipeline enables that the top level hands to each lane.
	typedef struct packed {
		logic accept;
		logic load_s2;
	} lane_ctl_t;

	// What a lane reports for the item in its second stage.
	typedef struct packed {
		trend_t trend;
		logic   full;
	} lane_res_t;

endpackage

@@ rtl/core/mdir_if.sv @@
// ----------------------------------------------------------------------------
// Channel interfaces
// Valid/ready channels for sample pairs, direction results and threshold writes.
// ----------------------------------------------------------------------------
interface mdir_in_if;
	import mdir_pkg::*;
	logic    valid;
	logic    ready;
	sample_t left_sample;
	sample_t right_sample;
	modport source (output valid, output left_sample, output right_sample, input ready);
	modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface mdir_out_if;
	import mdir_pkg::*;
	logic                valid;
	logic                ready;
	logic [DIR_BITS-1:0] direction;
	modport source (output valid, output direction, input ready);
	modport sink   (input valid, input direction, output ready);
endinterface

interface mdir_cfg_if;
	import mdir_pkg::*;
	logic                   valid;
	logic                   ready;
	logic [THRESH_BITS-1:0] still_threshold;
	modport source (output valid, output still_threshold, input ready);
	modport sink   (input valid, input still_threshold, output ready);
endinterface

@@ rtl/core/mdir_lane.sv @@
// ----------------------------------------------------------------------------
// mdir_lane
// One detector side: change gate, history shift register and trend count.
// ----------------------------------------------------------------------------
module mdir_lane (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mdir_pkg::lane_ctl_t             ctl,
	input  mdir_pkg::sample_t               sample,
	input  logic [mdir_pkg::THRESH_BITS-1:0] threshold,
	output mdir_pkg::lane_res_t             res
);
	import mdir_pkg::*;

	sample_t                   prev_q;
	sample_t                   hist_q [HISTORY_DEPTH];
	sample_t                   mag;
	logic                      moved;
	logic [HISTORY_DEPTH-1:1]  rise_d, fall_d;
	logic [HISTORY_DEPTH-1:1]  rise_s2, fall_s2;
	logic                      full_d, full_s2;
	logic                      run;
	logic [CNT_BITS-1:0]       rise_cnt, fall_cnt;

	assign mag   = (sample >= prev_q) ? (sample - prev_q) : (prev_q - sample);
	assign moved = (mag != '0) && (CMP_BITS'(mag) >= CMP_BITS'(threshold));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
		end else if (ctl.accept) begin
			prev_q <= sample;
			if (moved) begin
				hist_q[0] <= sample;
				for (int i = 1; i < HISTORY_DEPTH; i++) hist_q[i] <= hist_q[i-1];
			end else begin
				for (int i = 0; i < HISTORY_DEPTH; i++) hist_q[i] <= '0;
			end
		end
	end

	// Neighbor compares over the leading run of occupied entries, starting at entry 1.
	always_comb begin
		run    = 1'b1;
		full_d = (hist_q[0] != '0);
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			run       = run && (hist_q[i] != '0);
			full_d    = full_d && (hist_q[i] != '0);
			rise_d[i] = run && (hist_q[i] < hist_q[i-1]);
			fall_d[i] = run && (hist_q[i] > hist_q[i-1]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			rise_s2 <= rise_d;
			fall_s2 <= fall_d;
			full_s2 <= full_d;
		end
	end

	always_comb begin
		rise_cnt = '0;
		fall_cnt = '0;
		for (int i = 1; i < HISTORY_DEPTH; i++) begin
			rise_cnt = rise_cnt + CNT_BITS'(rise_s2[i]);
			fall_cnt = fall_cnt + CNT_BITS'(fall_s2[i]);
		end
		res.full = full_s2;
		if (rise_cnt > fall_cnt)       res.trend = TREND_UP;
		else if (rise_cnt == fall_cnt) res.trend = TREND_NEUTRAL;
		else                           res.trend = TREND_DOWN;
	end

endmodule

@@ rtl/core/mdir_merge.sv @@
// ----------------------------------------------------------------------------
// mdir_merge
// Combines the two side trends into one direction code.
// ----------------------------------------------------------------------------
module mdir_merge (
	input  mdir_pkg::lane_res_t              left_res,
	input  mdir_pkg::lane_res_t              right_res,
	output logic [mdir_pkg::DIR_BITS-1:0]    direction
);
	import mdir_pkg::*;

	always_comb begin
		direction = DIR_NONE;
		if (left_res.full || right_res.full) begin
			if (right_res.trend == TREND_UP || left_res.trend == TREND_DOWN) begin
				direction = DIR_RIGHT;
			end else if (right_res.trend == TREND_DOWN || left_res.trend == TREND_UP) begin
				direction = DIR_LEFT;
			end
		end
	end

endmodule

@@ rtl/core/two_sensor_motion_direction_top.sv @@
// ----------------------------------------------------------------------------
// two_sensor_motion_direction_top
// Motion direction from a stream of left/right detector sample pairs.
// ----------------------------------------------------------------------------
// Each sample-pair transaction yields exactly one direction transaction, in
// order. The block takes one transaction per cycle unless the pipeline is
// full behind a stalled consumer. An accepted pair first updates each side's
// history register; the neighbor compares of both histories are then
// registered, and from those registers the rises and falls are counted, the
// two trends merged and the output register loaded, which makes the result
// valid. Throughput is set by the history update of each lane. The three
// stages hold up to three items, so the block keeps accepting while a
// finished result waits on a stalled consumer until the pipeline is full.
// The threshold register resets to 2 and may be written at any time the
// block is idle; its write channel is always ready.
module two_sensor_motion_direction_top (
	input  logic        clk,
	input  logic        arst_n,
	mdir_in_if.sink     samples,
	mdir_out_if.source  result,
	mdir_cfg_if.sink    cfg
);
	import mdir_pkg::*;

	logic [THRESH_BITS-1:0] thresh_q;
	logic                   valid_s1, valid_s2;
	logic                   out_valid_q;
	logic [DIR_BITS-1:0]    out_dir_q;
	logic                   ld_out, ld_s2, ld_s1, accept;
	lane_ctl_t              lane_ctl;
	lane_res_t              left_res, right_res;
	logic [DIR_BITS-1:0]    direction;

	// Threshold register; a write is always taken at once.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
		end else if (cfg.valid) begin
			thresh_q <= cfg.still_threshold;
		end
	end

	// Each stage loads when it is empty or its contents move on downstream.
	// Stage one is the history register itself, which stays frozen while
	// stage one holds an item that cannot advance.
	assign ld_out = !out_valid_q || result.ready;
	assign ld_s2  = !valid_s2 || ld_out;
	assign ld_s1  = !valid_s1 || ld_s2;
	assign samples.ready = ld_s1;
	assign accept = samples.valid && ld_s1;

	assign lane_ctl.accept  = accept;
	assign lane_ctl.load_s2 = ld_s2 && valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s1)  valid_s1    <= samples.valid;
			if (ld_s2)  valid_s2    <= valid_s1;
			if (ld_out) out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_out && valid_s2) begin
			out_dir_q <= direction;
		end
	end

	// The two sides run as identical lanes.
	mdir_lane u_left (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (lane_ctl),
		.sample    (samples.left_sample),
		.threshold (thresh_q),
		.res       (left_res)
	);

	mdir_lane u_right (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (lane_ctl),
		.sample    (samples.right_sample),
		.threshold (thresh_q),
		.res       (right_res)
	);

	mdir_merge u_merge (
		.left_res  (left_res),
		.right_res (right_res),
		.direction (direction)
	);

	assign result.valid     = out_valid_q;
	assign result.direction = out_dir_q;

`ifndef SYNTHESIS
	// An empty first stage never blocks a new sample transaction.
	a_ready_when_s1_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> samples.ready)
		else $error("input stalled with empty first stage");

	// A stalled second stage keeps its item.
	a_s2_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !ld_out) |=> valid_s2)
		else $error("second stage lost an item while stalled");

	// The merge never produces the unused direction code.
	a_dir_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_dir_q == DIR_NONE || out_dir_q == DIR_RIGHT
			|| out_dir_q == DIR_LEFT))
		else $error("invalid direction code");

	// A result taken with nothing behind it leaves the output empty.
	a_out_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result.ready && !valid_s2) |=> !out_valid_q)
		else $error("output repeated a result");
`endif

endmodule

@@ dv/mdir_direction_checker.sv @@
// ----------------------------------------------------------------------------
// mdir_direction_checker
// Watches the sample, direction and threshold channels of the motion direction
// detector, predicts one direction per accepted sample pair and compares it
// with the direction transactions in order.
// ----------------------------------------------------------------------------
module mdir_direction_checker
	import mdir_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  sample_t                left_sample,
	input  sample_t                right_sample,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [DIR_BITS-1:0]    direction,
	input  logic                   cfg_valid,
	input  logic                   cfg_ready,
	input  logic [THRESH_BITS-1:0] still_threshold,
	output int                     mismatches,
	output int                     pending
);

	// Newest sample at index 0.
	typedef logic [HISTORY_DEPTH-1:0][SAMPLE_BITS-1:0] history_t;

	logic [THRESH_BITS-1:0] thresh;
	sample_t                last_left;
	sample_t                last_right;
	history_t               left_hist;
	history_t               right_hist;
	logic [DIR_BITS-1:0]    expected_dirs[$];
	logic [DIR_BITS-1:0]    want;
	int                     miss_count = 0;

	assign mismatches = miss_count;

	// A change that reaches the threshold shifts the sample in; anything else,
	// an exactly zero change included, empties the whole history.
	function automatic history_t advanced(history_t h, sample_t prev, sample_t cur);
		int unsigned mag;
		mag = (cur >= prev) ? cur - prev : prev - cur;
		if (mag != 0 && mag >= thresh)
			return {h[HISTORY_DEPTH-2:0], cur};
		return '0;
	endfunction

	function automatic bit all_filled(history_t h);
		for (int i = 0; i < HISTORY_DEPTH; i++)
			if (h[i] == '0)
				return 1'b0;
		return 1'b1;
	endfunction

	// Counting walks from the newest pair and stops at the first empty entry
	// at index 1 or beyond, so an empty newest entry is still compared.
	function automatic trend_t slope(history_t h);
		int rises;
		int falls;
		rises = 0;
		falls = 0;
		for (int i = 1; i < HISTORY_DEPTH && h[i] != '0; i++) begin
			if (h[i] > h[i-1])
				falls++;
			else if (h[i] < h[i-1])
				rises++;
		end
		if (rises > falls)
			return TREND_UP;
		if (rises == falls)
			return TREND_NEUTRAL;
		return TREND_DOWN;
	endfunction

	function automatic logic [DIR_BITS-1:0] heading(history_t lh, history_t rh);
		trend_t tl;
		trend_t tr;
		tl = slope(lh);
		tr = slope(rh);
		if (!all_filled(lh) && !all_filled(rh))
			return DIR_NONE;
		if (tr == TREND_UP || tl == TREND_DOWN)
			return DIR_RIGHT;
		if (tr == TREND_DOWN || tl == TREND_UP)
			return DIR_LEFT;
		return DIR_NONE;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh     = THRESH_RESET;
			last_left  = '0;
			last_right = '0;
			left_hist  = '0;
			right_hist = '0;
			miss_count = 0;
			expected_dirs.delete();
			pending   <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_dirs.size() == 0) begin
					miss_count++;
					$display("%0t: direction mismatch: expected none, actual %0d",
						$time, direction);
				end else begin
					want = expected_dirs.pop_front();
					if (direction !== want) begin
						miss_count++;
						$display("%0t: direction mismatch: expected %0d, actual %0d",
							$time, want, direction);
					end
				end
			end
			if (in_valid && in_ready) begin
				left_hist  = advanced(left_hist, last_left, left_sample);
				right_hist = advanced(right_hist, last_right, right_sample);
				last_left  = left_sample;
				last_right = right_sample;
				expected_dirs.push_back(heading(left_hist, right_hist));
			end
			if (cfg_valid && cfg_ready)
				thresh = still_threshold;
			pending <= expected_dirs.size();
		end
	end

endmodule

@@ dv/two_sensor_motion_direction_top_tb.sv @@
// ----------------------------------------------------------------------------
// two_sensor_motion_direction_top_tb
// Drives sample pairs and threshold writes into the motion direction detector,
// stalls the direction channel, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module two_sensor_motion_direction_top_tb;
	import mdir_pkg::*;

	// Shapes of the per-side sample sequences. Ramps fill a history with a
	// clear trend, the others exercise mixed trends, clears and noise.
	typedef enum int {
		WALK_UP,
		WALK_DOWN,
		ZIGZAG,
		JITTER,
		HOLD,
		NOISE
	} walk_t;

	// How the direction receiver paces its ready.
	typedef enum int {
		SINK_FREE,
		SINK_LIGHT,
		SINK_HEAVY
	} sink_mode_t;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 141;
	localparam int NUM_PHASES   = 8;
	localparam int HOLD_CYCLES  = 60;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_BITS) - 1;
	localparam int THRESH_MAX   = (1 << THRESH_BITS) - 1;

	logic clk;
	logic arst_n;

	mdir_in_if  sample_ch ();
	mdir_out_if dir_ch ();
	mdir_cfg_if thresh_ch ();

	int         mismatches;
	int         pending;
	int         cycles;

	// Sender state shared by the stimulus tasks.
	bit         gaps_on;
	int         burst_left;
	int         cur_thresh;
	sample_t    lval;
	sample_t    rval;
	walk_t      lkind;
	walk_t      rkind;
	int         sent;
	int         seg_len;
	int         phase_thresh[NUM_PHASES];

	// Receiver controls. The stimulus only requests a hold-off; the receiver
	// counts it down in its own process.
	sink_mode_t sink_mode;
	int         hold_request;
	int         hold_count;

	two_sensor_motion_direction_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (sample_ch),
		.result  (dir_ch),
		.cfg     (thresh_ch)
	);

	mdir_direction_checker watch (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (sample_ch.valid),
		.in_ready        (sample_ch.ready),
		.left_sample     (sample_ch.left_sample),
		.right_sample    (sample_ch.right_sample),
		.out_valid       (dir_ch.valid),
		.out_ready       (dir_ch.ready),
		.direction       (dir_ch.direction),
		.cfg_valid       (thresh_ch.valid),
		.cfg_ready       (thresh_ch.ready),
		.still_threshold (thresh_ch.still_threshold),
		.mismatches      (mismatches),
		.pending         (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Hard stop. A correct run finishes far below this, even with the
	// heaviest receiver stalls and the longest sender gaps on every item.
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Mismatches found");
		$finish;
	end

	// Direction receiver. Each cycle it either counts down a requested
	// hold-off or applies the stall pattern of the current mode.
	initial begin
		hold_count   = 0;
		dir_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request != 0) begin
				hold_count   = hold_request;
				hold_request = 0;
			end
			if (hold_count != 0) begin
				hold_count--;
				dir_ch.ready <= 1'b0;
			end else begin
				case (sink_mode)
					SINK_FREE:  dir_ch.ready <= 1'b1;
					SINK_LIGHT: dir_ch.ready <= ($urandom_range(0, 3) != 0);
					default:    dir_ch.ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Picks the shape of the next segment for one side. Ramps dominate so
	// that full histories and real trends come up often.
	function automatic walk_t pick_walk();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3)
			return WALK_UP;
		if (r < 6)
			return WALK_DOWN;
		if (r == 6)
			return ZIGZAG;
		if (r == 7)
			return JITTER;
		if (r == 8)
			return HOLD;
		return NOISE;
	endfunction

	// Starting point of a segment: ramps begin where they have room to run.
	function automatic sample_t seed_sample(walk_t kind, sample_t cur);
		if (kind == WALK_UP)
			return sample_t'($urandom_range(1, 1500));
		if (kind == WALK_DOWN)
			return sample_t'($urandom_range(2600, SAMPLE_MAX));
		return cur;
	endfunction

	// Next sample of one side. Strides sit at or just above the threshold, jitter
	// below it, so that both sides of the comparison are hit; ramps that run off
	// the range reflect back. Now and then a zero sample lands in the history.
	function automatic sample_t step_sample(walk_t kind, sample_t cur, int th, int pos);
		int stride;
		int base;
		int v;
		base   = cur;
		stride = th + int'($urandom_range(0, 3));
		if ($urandom_range(0, 7) == 0)
			stride = th + int'($urandom_range(0, 400));
		case (kind)
			WALK_UP:   v = base + stride;
			WALK_DOWN: v = base - stride;
			ZIGZAG:    v = pos[0] ? base + stride : base - stride;
			JITTER: begin
				v = int'($urandom_range(0, (th > 0) ? th - 1 : 0));
				v = (base + v <= SAMPLE_MAX) ? base + v : base - v;
			end
			HOLD:      v = base;
			default:   v = int'($urandom_range(0, SAMPLE_MAX));
		endcase
		if (v > SAMPLE_MAX || v < 0)
			v = 2 * base - v;
		if (v > SAMPLE_MAX || v < 0)
			v = (base >= 2048) ? 0 : SAMPLE_MAX;
		if ($urandom_range(0, 39) == 0)
			v = 0;
		return sample_t'(v);
	endfunction

	// Offers one sample pair and returns at the edge that accepts it. Bursts
	// of random length are separated by random gaps when gaps are enabled;
	// valid stays high across back-to-back transactions.
	task automatic send_pair(sample_t l, sample_t r);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gaps_on) begin
				gap = $urandom_range(1, 6);
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		sample_ch.valid        <= 1'b1;
		sample_ch.left_sample  <= l;
		sample_ch.right_sample <= r;
		do @(posedge clk); while (!sample_ch.ready);
		lval = l;
		rval = r;
	endtask

	// Stops offering and waits until every predicted direction has come out.
	// The extra edge lets the checker count the transaction accepted last.
	task automatic wait_idle();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_threshold(int value);
		thresh_ch.valid           <= 1'b1;
		thresh_ch.still_threshold <= value[THRESH_BITS-1:0];
		do @(posedge clk); while (!thresh_ch.ready);
		thresh_ch.valid <= 1'b0;
		cur_thresh = value;
	endtask

	initial begin
		arst_n       = 1'b0;
		hold_request = 0;
		sink_mode    = SINK_FREE;
		gaps_on      = 1'b0;
		burst_left   = 0;
		cur_thresh   = THRESH_RESET;
		lval         = '0;
		rval         = '0;
		sample_ch.valid           <= 1'b0;
		sample_ch.left_sample     <= '0;
		sample_ch.right_sample    <= '0;
		thresh_ch.valid           <= 1'b0;
		thresh_ch.still_threshold <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold. A zero change right after
		// reset clears, the largest sample is a real change, and a change of
		// one stays below the threshold.
		send_pair('0, '0);
		send_pair(sample_t'(SAMPLE_MAX), sample_t'(SAMPLE_MAX));
		send_pair(sample_t'(SAMPLE_MAX - 1), sample_t'(SAMPLE_MAX - 1));
		// Left ramps up and right ramps down until both histories are full.
		for (int k = 1; k <= HISTORY_DEPTH; k++)
			send_pair(sample_t'(100 * k), sample_t'(4100 - 100 * k));
		// A zero on the left is a real change and becomes an empty newest
		// entry; a second zero is no change and empties the left history.
		send_pair('0, sample_t'(3200));
		send_pair('0, sample_t'(3300));
		// A repeated right sample empties the right history as well.
		send_pair(sample_t'(5), sample_t'(3300));

		// With a zero threshold any nonzero change counts, but an exactly
		// zero change still clears.
		wait_idle();
		write_threshold(0);
		send_pair(sample_t'(6), sample_t'(3301));
		send_pair(sample_t'(6), sample_t'(3301));
		send_pair(sample_t'(SAMPLE_MAX), '0);

		// Random part, one threshold setting per phase, the extremes among
		// them. Two phases draw their threshold at random.
		phase_thresh = '{0, 1, 37, THRESH_MAX, 300, 0, 0, THRESH_RESET};
		phase_thresh[5] = $urandom_range(0, 64);
		phase_thresh[6] = $urandom_range(0, THRESH_MAX);
		for (int p = 0; p < NUM_PHASES; p++) begin
			// Every phase starts from an idle block: the sender has paused
			// until every expected direction has been received.
			wait_idle();
			write_threshold(phase_thresh[p]);
			sink_mode  = sink_mode_t'(p % 3);
			gaps_on    = (p % 2 == 1) && (p % 3 != 2);
			burst_left = 0;
			// In the heavy phases the receiver also goes away for a long
			// stretch while the sender keeps offering back to back, so the
			// pipeline fills and the sample channel backs up.
			if (p % 3 == 2)
				hold_request = HOLD_CYCLES;
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				seg_len = $urandom_range(4, 14);
				lkind   = pick_walk();
				rkind   = pick_walk();
				lval    = seed_sample(lkind, lval);
				rval    = seed_sample(rkind, rval);
				for (int k = 0; k < seg_len && sent < PHASE_ITEMS; k++) begin
					send_pair(step_sample(lkind, lval, cur_thresh, k),
						step_sample(rkind, rval, cur_thresh, k));
					sent++;
				end
			end
		end

		wait_idle();
		// More edges so that a stray direction after the last one
		// would still be seen by the checker.
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/mdir_pkg.sv
rtl/core/mdir_if.sv
rtl/core/mdir_lane.sv
rtl/core/mdir_merge.sv
rtl/core/two_sensor_motion_direction_top.sv
dv/mdir_direction_checker.sv
dv/two_sensor_motion_direction_top_tb.sv
